@@ hdl/bmp_pkg.sv @@
// Shared types and constants for the 24-bit BMP stream decoder.
// No dependencies.
package bmp_pkg;

	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;
	localparam int unsigned DIM_W      = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);
	localparam int unsigned HDR_BYTES  = 54;
	localparam logic [15:0] BM_MAGIC   = 16'h4D42;
	localparam logic [15:0] BPP_24     = 16'd24;
	localparam int unsigned Q_DEPTH    = 4;
	localparam int unsigned Q_AW       = $clog2(Q_DEPTH);

	typedef enum logic [1:0] {
		KIND_PIXEL   = 2'd0,
		KIND_HDR_OK  = 2'd1,
		KIND_HDR_BAD = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_MAGIC    = 3'd1,
		ERR_DEPTH    = 3'd2,
		ERR_COMPRESS = 3'd3,
		ERR_SIZE     = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_PIXELS = 3'b010,
		PH_IDLE   = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       start_file;
	} in_item_t;

	typedef struct packed {
		kind_t        kind;
		logic [31:0]  rgba;
		logic [23:0]  pixel_index;
		logic [12:0]  image_width;
		logic [12:0]  image_height;
		err_t         error_code;
		logic         last_pixel;
	} out_item_t;

	// Event passed from the parser to the formatter
	typedef struct packed {
		kind_t            kind;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [23:0]      row_base;
		logic [DIM_W-1:0] column;
		logic [12:0]      width;
		logic [12:0]      height;
		err_t             err;
		logic             last;
	} event_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ hdl/bmp_front.sv @@
// Byte parser: header collection and checks, pixel assembly, padding drop.
// Depends on bmp_pkg.
module bmp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  bmp_pkg::in_item_t item,
	output logic             push,
	output bmp_pkg::event_t  ev
);
	import bmp_pkg::*;

	phase_t           phase_q;
	logic [5:0]       hdr_cnt_q;
	logic [15:0]      magic_q;
	logic [31:0]      width_q;
	logic [31:0]      height_q;
	logic [15:0]      bpp_q;
	logic [31:0]      comp_q;
	logic             flip_q;
	logic [DIM_W-1:0] w_q;
	logic [DIM_W-1:0] h_q;
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic [23:0]      row_base_q;
	logic [1:0]       bip_q;
	logic [1:0]       pad_q;
	logic [15:0]      held_q;

	phase_t      ph;
	logic [5:0]  cnt;
	logic [15:0] magic_c;
	logic [31:0] width_c;
	logic [31:0] height_c;
	logic [15:0] bpp_c;
	logic [31:0] comp_c;
	logic [31:0] h_abs;
	logic [5:0]  off;
	logic [7:0]  b;
	err_t        err;
	logic        flip_c;
	logic [DIM_W-1:0]   w_c;
	logic [DIM_W-1:0]   h_c;
	logic [2*DIM_W-1:0] prod;
	logic        row_end;
	logic        img_end;

	assign b   = item.file_byte;
	assign ph  = item.start_file ? PH_HEADER : phase_q;
	assign cnt = item.start_file ? 6'd0 : hdr_cnt_q;

	// Merge the current byte into the header words
	always_comb begin
		magic_c  = item.start_file ? 16'd0 : magic_q;
		width_c  = item.start_file ? 32'd0 : width_q;
		height_c = item.start_file ? 32'd0 : height_q;
		bpp_c    = item.start_file ? 16'd0 : bpp_q;
		comp_c   = item.start_file ? 32'd0 : comp_q;
		off      = 6'd0;
		if (cnt < 6'd2) begin
			magic_c[8*cnt[0] +: 8] = b;
		end else if (cnt >= 6'd18 && cnt < 6'd22) begin
			off = cnt - 6'd18;
			width_c[8*off[1:0] +: 8] = b;
		end else if (cnt >= 6'd22 && cnt < 6'd26) begin
			off = cnt - 6'd22;
			height_c[8*off[1:0] +: 8] = b;
		end else if (cnt >= 6'd28 && cnt < 6'd30) begin
			off = cnt - 6'd28;
			bpp_c[8*off[0] +: 8] = b;
		end else if (cnt >= 6'd30 && cnt < 6'd34) begin
			off = cnt - 6'd30;
			comp_c[8*off[1:0] +: 8] = b;
		end
	end

	assign h_abs  = height_q[31] ? (~height_q + 32'd1) : height_q;
	assign flip_c = !height_q[31] && (height_q != 32'd0);
	assign w_c    = width_q[DIM_W-1:0];
	assign h_c    = h_abs[DIM_W-1:0];
	assign prod   = (h_c - DIM_W'(1)) * w_c;

	always_comb begin
		if (magic_q != BM_MAGIC)
			err = ERR_MAGIC;
		else if (bpp_q != BPP_24)
			err = ERR_DEPTH;
		else if (comp_q != 32'd0)
			err = ERR_COMPRESS;
		else if (width_q > 32'(MAX_WIDTH) || h_abs > 32'(MAX_HEIGHT))
			err = ERR_SIZE;
		else
			err = ERR_NONE;
	end

	assign row_end = ((DIM_W+1)'(col_q) + 1'b1) >= (DIM_W+1)'(w_q);
	assign img_end = ((DIM_W+1)'(row_q) + 1'b1) >= (DIM_W+1)'(h_q);

	always_comb begin
		push        = 1'b0;
		ev          = '0;
		ev.kind     = KIND_PIXEL;
		ev.err      = ERR_NONE;
		ev.red      = b;
		ev.green    = held_q[15:8];
		ev.blue     = held_q[7:0];
		ev.row_base = row_base_q;
		ev.column   = col_q;
		ev.width    = 13'(w_q);
		ev.height   = 13'(h_q);
		ev.last     = img_end && row_end;
		case (ph)
			PH_HEADER: begin
				if (take && cnt == 6'(HDR_BYTES - 1)) begin
					push   = 1'b1;
					ev.err = err;
					if (err != ERR_NONE) begin
						ev.kind   = KIND_HDR_BAD;
						ev.width  = 13'd0;
						ev.height = 13'd0;
					end else begin
						ev.kind   = KIND_HDR_OK;
						ev.width  = 13'(width_q);
						ev.height = 13'(h_abs);
					end
					ev.last = 1'b0;
				end
			end
			PH_PIXELS: begin
				push = take && pad_q == 2'd0 && bip_q == 2'd2;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= '0;
			magic_q    <= '0;
			width_q    <= '0;
			height_q   <= '0;
			bpp_q      <= '0;
			comp_q     <= '0;
			flip_q     <= 1'b0;
			w_q        <= '0;
			h_q        <= '0;
			col_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
			bip_q      <= '0;
			pad_q      <= '0;
			held_q     <= '0;
		end else if (take) begin
			case (ph)
				PH_HEADER: begin
					hdr_cnt_q <= cnt + 6'd1;
					magic_q   <= magic_c;
					width_q   <= width_c;
					height_q  <= height_c;
					bpp_q     <= bpp_c;
					comp_q    <= comp_c;
					phase_q   <= PH_HEADER;
					if (cnt == 6'(HDR_BYTES - 1)) begin
						if (err != ERR_NONE) begin
							phase_q <= PH_IDLE;
						end else begin
							flip_q     <= flip_c;
							w_q        <= w_c;
							h_q        <= h_c;
							col_q      <= '0;
							row_q      <= '0;
							bip_q      <= '0;
							pad_q      <= '0;
							held_q     <= '0;
							row_base_q <= flip_c ? 24'(prod) : 24'd0;
							phase_q    <= (w_c == '0 || h_c == '0) ? PH_IDLE : PH_PIXELS;
						end
					end
				end
				PH_PIXELS: begin
					phase_q <= PH_PIXELS;
					if (pad_q != 2'd0) begin
						pad_q <= pad_q - 2'd1;
					end else if (bip_q == 2'd0) begin
						held_q[7:0] <= b;
						bip_q       <= 2'd1;
					end else if (bip_q == 2'd1) begin
						held_q[15:8] <= b;
						bip_q        <= 2'd2;
					end else begin
						bip_q <= 2'd0;
						if (row_end) begin
							col_q <= '0;
							row_q <= row_q + DIM_W'(1);
							if (img_end) begin
								phase_q <= PH_IDLE;
							end else begin
								pad_q      <= 2'(2'd0 - 2'(w_q[1:0] * 2'd3));
								row_base_q <= flip_q ? row_base_q - 24'(w_q)
										: row_base_q + 24'(w_q);
							end
						end else begin
							col_q <= col_q + DIM_W'(1);
						end
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/bmp_queue.sv @@
// Short event queue between parser and formatter.
// Depends on bmp_pkg.
module bmp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bmp_pkg::event_t    push_ev,
	input  logic               pop,
	output bmp_pkg::event_t    head,
	output bmp_pkg::q_status_t stat
);
	import bmp_pkg::*;

	event_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;

	assign head       = mem_q[rd_q];
	assign stat.full  = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign stat.empty = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + Q_AW'(1);
			if (pop)
				rd_q <= rd_q + Q_AW'(1);
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (arst_n) begin
			assert (!(push && stat.full && !pop)) else $error("queue overflow");
			assert (!(pop && stat.empty)) else $error("queue underflow");
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count out of range");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + (Q_AW+1)'(1))
		else $error("queue count did not advance");
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop) else $error("pop from empty queue");

endmodule

@@ hdl/bmp_back.sv @@
// Formatter: turns queued events into result items in an output register.
// Depends on bmp_pkg.
module bmp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  bmp_pkg::event_t    head,
	input  bmp_pkg::q_status_t stat,
	output logic               pop,
	output logic               valid,
	input  logic               ready,
	output bmp_pkg::out_item_t data
);
	import bmp_pkg::*;

	logic      valid_q;
	out_item_t data_q;
	out_item_t nxt;

	assign pop   = !stat.empty && (!valid_q || ready);
	assign valid = valid_q;
	assign data  = data_q;

	always_comb begin
		nxt              = '0;
		nxt.kind         = head.kind;
		nxt.image_width  = head.width;
		nxt.image_height = head.height;
		nxt.error_code   = head.err;
		nxt.last_pixel   = head.last;
		if (head.kind == KIND_PIXEL) begin
			nxt.rgba        = {8'hFF, head.blue, head.green, head.red};
			nxt.pixel_index = head.row_base + 24'(head.column);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || ready) begin
			valid_q <= !stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			data_q <= nxt;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !ready) |=> valid_q && data_q == $past(data_q))
		else $error("result changed while stalled");
	a_pixel_err: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && data_q.kind == KIND_PIXEL) |-> data_q.error_code == ERR_NONE)
		else $error("pixel carries error code");
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && data_q.kind == KIND_PIXEL) |-> data_q.rgba[31:24] == 8'hFF)
		else $error("pixel alpha not opaque");

endmodule

@@ hdl/bmp24_stream_decoder.sv @@
// 24-bit BMP stream decoder top level: one byte per cycle in, results out.
// A result passes through the event queue and then the output register.
// Throughput: one byte per cycle while the event queue is not full.
// A 4-entry event queue and an output register decouple input and output stalls.
// Reset (arst_n low) clears the parser to header phase and empties the queue.
module bmp24_stream_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bmp_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bmp_pkg::out_item_t out_data
);
	import bmp_pkg::*;

	logic      take;
	logic      push;
	logic      pop;
	event_t    ev;
	event_t    head;
	q_status_t stat;

	assign in_ready = !stat.full;
	assign take     = in_valid && in_ready;

	bmp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (in_data),
		.push   (push),
		.ev     (ev)
	);

	bmp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ev (ev),
		.pop     (pop),
		.head    (head),
		.stat    (stat)
	);

	bmp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.valid  (out_valid),
		.ready  (out_ready),
		.data   (out_data)
	);

	a_push_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> take) else $error("event without accepted item");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !in_ready) else $error("ready while queue full");
	a_out_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.kind == KIND_PIXEL || out_data.kind == KIND_HDR_OK
			|| out_data.kind == KIND_HDR_BAD)) else $error("bad result kind");

endmodule
